>>> hw/rtl/ede_pkg.sv
`default_nettype none
package ede_pkg;

  localparam int SYM_W = 21;
  localparam int OUT_W = 7;

  // register index (word address bit of paddr)
  localparam logic REG_TRANSPOSITION_MODE = 1'b0;

  typedef enum logic [1:0] {
    CMD_APPEND_FIRST  = 2'd0,
    CMD_APPEND_SECOND = 2'd1,
    CMD_COMPUTE       = 2'd2
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic [1:0]       command;
    logic [SYM_W-1:0] symbol;
  } ede_in_t;

  typedef struct packed {
    logic [OUT_W-1:0] distance;
    logic [OUT_W-1:0] first_length;
    logic [OUT_W-1:0] second_length;
    logic             overflow;
  } ede_out_t;

  // control bits that travel with each row down the chain
  typedef struct packed {
    logic valid;
    logic ge2;
  } link_ctl_t;

endpackage
`default_nettype wire

>>> hw/rtl/edit_distance_engine.sv
`default_nettype none
// edit distance engine (optimal string alignment / levenshtein)
//
// command channel: a beat on request is taken at a clock edge with start high
// and busy low. command 0 appends symbol to the first word, 1 to the second,
// 2 computes the distance and clears both words, 3 is ignored.
// appends never raise busy; symbols stream in one per cycle outside a compute.
// a compute holds busy while the first word streams out of its store and
// down a row of MAX_LEN cells, one cell per second-word symbol, each cell
// finishing one cost entry per cycle.
// the result beat then sits on result for exactly one cycle with done high,
// in the first cycle that busy is low again; the receiver cannot stall it and
// a new command may be taken in that same cycle.
// symbols past MAX_LEN are dropped and flag overflow in the next result.
// apb port: one register, transposition_mode at byte address 0, reset to 1.
// reset clears the counts, the overflow flag and the sequencer; the word
// stores are not cleared and need no clearing pass.
module edit_distance_engine #(
  parameter int MAX_LEN = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  ede_pkg::ede_in_t  request,
  output logic              done,
  output ede_pkg::ede_out_t result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import ede_pkg::*;

  localparam int AW   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW   = $clog2(MAX_LEN + 2);    // costs reach MAX_LEN + 1
  localparam int CNTW = $clog2(MAX_LEN + 1);
  localparam int TW   = $clog2(2 * MAX_LEN + 2);

  state_t state;
  state_t state_next;

  logic [TW-1:0]   cnt;
  logic [TW-1:0]   last;
  logic [CNTW-1:0] first_count;
  logic [CNTW-1:0] second_count;
  logic            dropped;
  logic            mode;

  logic accept;
  logic do_first;
  logic do_second;
  logic do_compute;
  logic first_full;
  logic second_full;
  logic rd_en;
  logic finish;

  // chain links, index 0 is the boundary column from the feeder
  link_ctl_t        ch_ctl    [0:MAX_LEN];
  logic [SYM_W-1:0] ch_a      [0:MAX_LEN];
  logic [SYM_W-1:0] ch_ap     [0:MAX_LEN];
  logic [SYM_W-1:0] ch_b      [0:MAX_LEN];
  logic [CW-1:0]    ch_d      [0:MAX_LEN];
  logic [CW-1:0]    ch_d_old  [0:MAX_LEN];
  logic [CW-1:0]    ch_dg_old [0:MAX_LEN];

  assign accept      = start && !busy;
  assign do_first    = accept && (request.command == CMD_APPEND_FIRST);
  assign do_second   = accept && (request.command == CMD_APPEND_SECOND);
  assign do_compute  = accept && (request.command == CMD_COMPUTE);
  assign first_full  = (first_count == CNTW'(MAX_LEN));
  assign second_full = (second_count == CNTW'(MAX_LEN));
  // the run ends on the count at which the last cell has settled
  assign last        = TW'(first_count) + TW'(MAX_LEN + 1);

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (do_compute) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cnt == last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy   = 1'b0;
    rd_en  = 1'b0;
    finish = 1'b0;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
      end
      ST_RUN: begin
        busy   = 1'b1;
        rd_en  = (cnt < TW'(first_count));
        finish = (cnt == last);
      end
      default: busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_compute) begin
      cnt <= '0;
    end else if (state == ST_RUN) begin
      cnt <= cnt + TW'(1);
    end
  end

  // word lengths and the drop flag, cleared once the result is captured
  always_ff @(posedge clk) begin
    if (rst || finish) begin
      first_count  <= '0;
      second_count <= '0;
      dropped      <= 1'b0;
    end else begin
      if (do_first) begin
        if (first_full) begin
          dropped <= 1'b1;
        end else begin
          first_count <= first_count + CNTW'(1);
        end
      end
      if (do_second) begin
        if (second_full) begin
          dropped <= 1'b1;
        end else begin
          second_count <= second_count + CNTW'(1);
        end
      end
    end
  end

  // result beat, one cycle wide
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= finish;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      result.distance      <= OUT_W'(ch_d[second_count]);
      result.first_length  <= OUT_W'(first_count);
      result.second_length <= OUT_W'(second_count);
      result.overflow      <= dropped;
    end
  end

  // apb register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TRANSPOSITION_MODE) ? {31'b0, mode} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b1;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == REG_TRANSPOSITION_MODE)) begin
      mode <= pwdata[0];
    end
  end

  // first word store and the boundary column
  ede_feeder #(
    .MAX_LEN (MAX_LEN),
    .AW      (AW),
    .CW      (CW)
  ) u_feeder (
    .clk    (clk),
    .rst    (rst),
    .init   (do_compute),
    .we     (do_first && !first_full),
    .waddr  (first_count[AW-1:0]),
    .wsym   (request.symbol),
    .rd_en  (rd_en),
    .raddr  (cnt[AW-1:0]),
    .ctl    (ch_ctl[0]),
    .a      (ch_a[0]),
    .ap     (ch_ap[0]),
    .d      (ch_d[0]),
    .d_old  (ch_d_old[0])
  );

  // boundary has no symbol and no older diagonal; cell 1 never uses them
  assign ch_b[0]      = '0;
  assign ch_dg_old[0] = '0;

  // one cell per second-word position, rows flow left to right
  for (genvar k = 1; k <= MAX_LEN; k++) begin : g_cell
    ede_cell #(
      .IDX (k),
      .AW  (AW),
      .CW  (CW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .init     (do_compute),
      .mode     (mode),
      .b_we     (do_second && !second_full),
      .b_addr   (second_count[AW-1:0]),
      .b_sym    (request.symbol),
      .l_ctl    (ch_ctl[k-1]),
      .l_a      (ch_a[k-1]),
      .l_ap     (ch_ap[k-1]),
      .l_b      (ch_b[k-1]),
      .l_d      (ch_d[k-1]),
      .l_d_old  (ch_d_old[k-1]),
      .l_dg_old (ch_dg_old[k-1]),
      .ctl      (ch_ctl[k]),
      .a        (ch_a[k]),
      .ap       (ch_ap[k]),
      .b        (ch_b[k]),
      .d        (ch_d[k]),
      .d_old    (ch_d_old[k]),
      .dg_old   (ch_dg_old[k])
    );
  end

endmodule
`default_nettype wire

>>> hw/rtl/ede_feeder.sv
`default_nettype none
module ede_feeder #(
  parameter int MAX_LEN = 64,
  parameter int AW      = 6,
  parameter int CW      = 7
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       init,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [ede_pkg::SYM_W-1:0]  wsym,
  input  logic                       rd_en,
  input  logic [AW-1:0]              raddr,
  output ede_pkg::link_ctl_t         ctl,
  output logic [ede_pkg::SYM_W-1:0]  a,
  output logic [ede_pkg::SYM_W-1:0]  ap,
  output logic [CW-1:0]              d,
  output logic [CW-1:0]              d_old
);
  import ede_pkg::*;

  logic [SYM_W-1:0] mem [0:MAX_LEN-1];
  logic [SYM_W-1:0] rd_data;
  logic             s1_valid;

  // first word store, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wsym;
    end
    if (rd_en) begin
      rd_data <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      ctl      <= '0;
    end else begin
      s1_valid  <= rd_en;
      ctl.valid <= s1_valid;
      if (s1_valid) begin
        ctl.ge2 <= (d != '0);
      end
    end
  end

  // boundary column: d is the row index i, d_old is i-1
  always_ff @(posedge clk) begin
    if (init) begin
      d <= '0;
    end else if (s1_valid) begin
      a     <= rd_data;
      ap    <= a;
      d     <= d + CW'(1);
      d_old <= d;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/ede_cell.sv
`default_nettype none
module ede_cell #(
  parameter int IDX = 1,
  parameter int AW  = 6,
  parameter int CW  = 7
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       init,
  input  logic                       mode,
  input  logic                       b_we,
  input  logic [AW-1:0]              b_addr,
  input  logic [ede_pkg::SYM_W-1:0]  b_sym,
  input  ede_pkg::link_ctl_t         l_ctl,
  input  logic [ede_pkg::SYM_W-1:0]  l_a,
  input  logic [ede_pkg::SYM_W-1:0]  l_ap,
  input  logic [ede_pkg::SYM_W-1:0]  l_b,
  input  logic [CW-1:0]              l_d,
  input  logic [CW-1:0]              l_d_old,
  input  logic [CW-1:0]              l_dg_old,
  output ede_pkg::link_ctl_t         ctl,
  output logic [ede_pkg::SYM_W-1:0]  a,
  output logic [ede_pkg::SYM_W-1:0]  ap,
  output logic [ede_pkg::SYM_W-1:0]  b,
  output logic [CW-1:0]              d,
  output logic [CW-1:0]              d_old,
  output logic [CW-1:0]              dg_old
);
  import ede_pkg::*;

  localparam logic HAS_PREV = (IDX >= 2);

  logic [CW-1:0] dg;
  logic [CW-1:0] v_edit;
  logic [CW-1:0] v_sub;
  logic [CW-1:0] v_swap;
  logic [CW-1:0] d_next;
  logic          swap_ok;

  always_comb begin
    v_edit  = (d < l_d) ? d + CW'(1) : l_d + CW'(1);
    v_sub   = l_d_old + ((l_a != b) ? CW'(1) : CW'(0));
    v_swap  = l_dg_old + CW'(1);
    swap_ok = mode && l_ctl.ge2 && HAS_PREV && (l_a == l_b) && (l_ap == b);
    d_next  = (v_sub < v_edit) ? v_sub : v_edit;
    if (swap_ok && (v_swap < d_next)) begin
      d_next = v_swap;
    end
  end

  always_ff @(posedge clk) begin
    if (b_we && (b_addr == AW'(IDX - 1))) begin
      b <= b_sym;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || init) begin
      ctl <= '0;
    end else begin
      ctl <= l_ctl;
    end
  end

  // d holds D[i][IDX], d_old D[i-1][IDX], dg/dg_old the diagonals used
  always_ff @(posedge clk) begin
    if (init) begin
      d <= CW'(IDX);
    end else if (l_ctl.valid) begin
      d      <= d_next;
      d_old  <= d;
      dg     <= l_d_old;
      dg_old <= dg;
      a      <= l_a;
      ap     <= l_ap;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/ede_checker.sv
`default_nettype none
module ede_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input ede_pkg::ede_in_t  request,
  input logic              done
);
  import ede_pkg::*;

  // a compute beat makes the block busy in the next cycle
  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (request.command == CMD_COMPUTE)) |=> busy)
    else $error("compute beat did not raise busy");

  // appends and unused commands never block or produce a result
  a_append_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (request.command != CMD_COMPUTE)) |=> (!busy && !done))
    else $error("append beat raised busy or done");

  // the result beat comes exactly when busy drops
  a_done_on_fall: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(busy)) |-> done)
    else $error("busy fell without a result beat");

  // a result beat lasts one cycle and never overlaps busy
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy ##1 !done))
    else $error("result beat overlapped busy or repeated");

endmodule

bind edit_distance_engine ede_checker u_ede_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .request (request),
  .done    (done)
);
`default_nettype wire

>>> tb/ede_tb_pkg.sv
package ede_tb_pkg;
  import ede_pkg::*;

  localparam int unsigned WORD_MAX = 64;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [SYM_W-1:0] SYM_TOP = 21'h10FFFF;

  class distance_scoreboard;
    bit swap_mode;
    logic [SYM_W-1:0] word_a [WORD_MAX];
    logic [SYM_W-1:0] word_b [WORD_MAX];
    int unsigned len_a;
    int unsigned len_b;
    bit dropped;
    ede_out_t expected_q [$];
    int unsigned errors;

    function new();
      swap_mode = 1'b1;
      len_a = 0;
      len_b = 0;
      dropped = 1'b0;
      errors = 0;
    endfunction

    // three rolling cost rows, the oldest one feeds the swap term
    function int unsigned osa_distance();
      int unsigned older [WORD_MAX+1];
      int unsigned prev [WORD_MAX+1];
      int unsigned cur [WORD_MAX+1];
      int unsigned v;
      for (int j = 0; j <= len_b; j++) prev[j] = j;
      for (int i = 1; i <= len_a; i++) begin
        cur[0] = i;
        for (int j = 1; j <= len_b; j++) begin
          v = prev[j] + 1;
          if (cur[j-1] + 1 < v) v = cur[j-1] + 1;
          if (prev[j-1] + (word_a[i-1] != word_b[j-1]) < v)
            v = prev[j-1] + (word_a[i-1] != word_b[j-1]);
          if (swap_mode && i >= 2 && j >= 2 && word_a[i-1] == word_b[j-2] &&
              word_a[i-2] == word_b[j-1] && older[j-2] + 1 < v)
            v = older[j-2] + 1;
          cur[j] = v;
        end
        older = prev;
        prev = cur;
      end
      return prev[len_b];
    endfunction

    function void note_request(ede_in_t req);
      ede_out_t res;
      case (req.command)
        CMD_APPEND_FIRST: begin
          if (len_a < WORD_MAX) begin
            word_a[len_a] = req.symbol;
            len_a++;
          end else dropped = 1'b1;
        end
        CMD_APPEND_SECOND: begin
          if (len_b < WORD_MAX) begin
            word_b[len_b] = req.symbol;
            len_b++;
          end else dropped = 1'b1;
        end
        CMD_COMPUTE: begin
          res.distance = OUT_W'(osa_distance());
          res.first_length = OUT_W'(len_a);
          res.second_length = OUT_W'(len_b);
          res.overflow = dropped;
          expected_q.push_back(res);
          len_a = 0;
          len_b = 0;
          dropped = 1'b0;
        end
        default: ;
      endcase
    endfunction

    function void check_field(string what, logic [OUT_W-1:0] want, logic [OUT_W-1:0] got);
      if (want != got) begin
        errors++;
        $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
      end
    endfunction

    function void check_result(ede_out_t got);
      ede_out_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual %0d/%0d/%0d/%0d", $time,
                 got.distance, got.first_length, got.second_length, got.overflow);
        return;
      end
      want = expected_q.pop_front();
      check_field("distance", want.distance, got.distance);
      check_field("first_length", want.first_length, got.first_length);
      check_field("second_length", want.second_length, got.second_length);
      check_field("overflow", OUT_W'(want.overflow), OUT_W'(got.overflow));
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

>>> tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ede_pkg::*;
  import ede_tb_pkg::*;

  localparam int unsigned CLK_HALF = 4;
  localparam int unsigned STALL_LIMIT = 4000;
  // long enough for a compute still in flight to finish, with headroom
  localparam int unsigned DRAIN_CYCLES = 2 * WORD_MAX + 8;
  localparam int unsigned PHASE_ITEMS = 125;
  localparam int unsigned PHASES = 6;
  localparam logic [2:0] MODE_ADDR = {REG_TRANSPOSITION_MODE, 2'b00};
  // word address one: no register there, writes must be dropped
  localparam logic [2:0] SPARE_ADDR = 3'd4;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  ede_in_t request;
  logic done;
  ede_out_t result;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  distance_scoreboard sb;
  int unsigned beats_sent;
  int unsigned stall_cycles;

  edit_distance_engine #(.MAX_LEN(WORD_MAX)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .done(done),
    .result(result),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // every result beat is checked against the oldest outstanding distance
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
  end

  // watchdog: count cycles with no command beat, no result and no register write
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (psel && penable && pready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  // idle with start low; request carries junk that must be ignored
  task automatic idle_cycle();
    @(negedge clk);
    start <= 1'b0;
    request <= {2'($urandom_range(3)), 21'($urandom_range(SYM_TOP))};
  endtask

  // hold the beat until the block takes it, then tell the scoreboard
  task automatic push_beat(input logic [1:0] cmd, input logic [SYM_W-1:0] sym);
    ede_in_t req;
    req.command = cmd;
    req.symbol = sym;
    @(negedge clk);
    start <= 1'b1;
    request <= req;
    do @(posedge clk); while (busy);
    sb.note_request(req);
    if (cmd != CMD_UNUSED) beats_sent++;
  endtask

  // random idle ahead of the beat, now and then an unused command as noise
  task automatic send(input logic [1:0] cmd, input logic [SYM_W-1:0] sym,
                      input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) idle_cycle();
    if ($urandom_range(24) == 0) push_beat(CMD_UNUSED, 21'($urandom_range(SYM_TOP)));
    push_beat(cmd, sym);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == MODE_ADDR) sb.swap_mode = data[0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // drop start, wait out every distance and any compute still in flight
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // mostly from a tiny alphabet so matches and swaps are common
  function automatic logic [SYM_W-1:0] pick_symbol(logic [SYM_W-1:0] pool [$]);
    if (pool.size() == 0 || $urandom_range(4) == 0) return SYM_W'($urandom_range(SYM_TOP));
    return pool[$urandom_range(pool.size() - 1)];
  endfunction

  // short words most of the time, a few full ones and a few long ones, some of which overflow
  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 2) return WORD_MAX;
    if (r < 8) return $urandom_range(WORD_MAX + 6, 48);
    return $urandom_range(10);
  endfunction

  // load a word pair in random interleave, then compute (now and then skipped or doubled)
  task automatic play_pair(input int unsigned idle_pct);
    logic [SYM_W-1:0] pool [$];
    logic [SYM_W-1:0] wa [$];
    logic [SYM_W-1:0] wb [$];
    logic [SYM_W-1:0] tmp;
    int unsigned n;
    int unsigned idx;
    n = $urandom_range(1, 4);
    repeat (n) pool.push_back(SYM_W'($urandom_range(SYM_TOP)));
    n = pick_length();
    repeat (n) wa.push_back(pick_symbol(pool));
    if ($urandom_range(1)) begin
      // second word is a lightly edited copy of the first
      wb = wa;
      repeat ($urandom_range(3)) begin
        idx = (wb.size() == 0) ? 0 : $urandom_range(wb.size() - 1);
        case ($urandom_range(3))
          0: begin
            if (idx + 1 < wb.size()) begin
              tmp = wb[idx];
              wb[idx] = wb[idx+1];
              wb[idx+1] = tmp;
            end
          end
          1: if (wb.size() != 0) wb[idx] = pick_symbol(pool);
          2: wb.insert(idx, pick_symbol(pool));
          default: if (wb.size() != 0) wb.delete(idx);
        endcase
      end
    end else begin
      n = pick_length();
      repeat (n) wb.push_back(pick_symbol(pool));
    end
    while (wa.size() + wb.size() != 0) begin
      if (wb.size() == 0 || (wa.size() != 0 && $urandom_range(1)))
        send(CMD_APPEND_FIRST, wa.pop_front(), idle_pct);
      else
        send(CMD_APPEND_SECOND, wb.pop_front(), idle_pct);
    end
    // broken sequences: a missing compute lets the words run on into the next
    // pair, a doubled one computes on empty words
    if ($urandom_range(24) != 0)
      send(CMD_COMPUTE, SYM_W'($urandom_range(SYM_TOP)), idle_pct);
    if ($urandom_range(30) == 0)
      send(CMD_COMPUTE, SYM_W'($urandom_range(SYM_TOP)), idle_pct);
  endtask

  // a pair that differs by one adjacent swap, symbols at both code point ends
  task automatic swapped_pair();
    push_beat(CMD_APPEND_FIRST, SYM_TOP);
    push_beat(CMD_APPEND_FIRST, '0);
    push_beat(CMD_APPEND_SECOND, '0);
    push_beat(CMD_APPEND_SECOND, SYM_TOP);
    push_beat(CMD_COMPUTE, SYM_TOP);
  endtask

  initial begin
    bit phase_mode [PHASES];
    int unsigned phase_idle [PHASES];
    int unsigned first_beat;
    phase_mode = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    // sender idle odds per phase, two phases each with none, heavy and light idling
    phase_idle = '{0, 84, 33, 0, 84, 33};
    sb = new();
    beats_sent = 0;
    stall_cycles = 0;
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // transposition on, then a write to the empty slot that must not clear it
    write_reg(MODE_ADDR, {31'($urandom), 1'b1});
    write_reg(SPARE_ADDR, {31'($urandom), 1'b0});

    // directed: both words empty
    push_beat(CMD_COMPUTE, '0);
    // one adjacent swap costs one with transposition on
    swapped_pair();
    // empty second word, then empty first word
    push_beat(CMD_APPEND_FIRST, 21'd5);
    push_beat(CMD_APPEND_FIRST, 21'd6);
    push_beat(CMD_APPEND_FIRST, 21'd7);
    push_beat(CMD_COMPUTE, '0);
    push_beat(CMD_APPEND_SECOND, 21'd1);
    push_beat(CMD_APPEND_SECOND, 21'd2);
    push_beat(CMD_COMPUTE, SYM_TOP);
    // unused command is ignored, then equal one-symbol words
    push_beat(CMD_UNUSED, 21'h0ABCDE);
    push_beat(CMD_APPEND_FIRST, 21'h1F0F0);
    push_beat(CMD_APPEND_SECOND, 21'h1F0F0);
    push_beat(CMD_COMPUTE, '0);
    // a single deletion
    push_beat(CMD_APPEND_FIRST, 21'd1);
    push_beat(CMD_APPEND_FIRST, 21'd2);
    push_beat(CMD_APPEND_FIRST, 21'd3);
    push_beat(CMD_APPEND_SECOND, 21'd1);
    push_beat(CMD_APPEND_SECOND, 21'd3);
    push_beat(CMD_COMPUTE, '0);
    settle();

    // plain levenshtein: the same swap now costs two
    write_reg(MODE_ADDR, {31'($urandom), 1'b0});
    swapped_pair();
    settle();

    // random phases, each with its own mode and idle rate
    for (int p = 0; p < PHASES; p++) begin
      write_reg(MODE_ADDR, {31'($urandom), phase_mode[p]});
      first_beat = beats_sent;
      while (beats_sent - first_beat < PHASE_ITEMS) play_pair(phase_idle[p]);
      settle();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
